@@ design/aarm_pkg.sv @@
// Shared types, constants and fixed-point helpers for the axis-angle rotation matrix block
`timescale 1ns / 1ps
package aarm_pkg;

    localparam int ZW = 34;
    typedef logic signed [ZW-1:0] t_wide;

    localparam t_wide FX_ONE     = 34'sd1073741824;
    localparam t_wide FX_PI      = 34'sd3373259426;
    localparam t_wide FX_HALF_PI = 34'sd1686629713;
    localparam t_wide FX_TWO_PI  = 34'sd6746518852;
    localparam t_wide FX_GAIN    = 34'sd652032874;

    localparam t_wide ATAN_LO [0:10] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576
    };

    typedef struct packed {
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic signed [31:0] angle;
    } t_in;

    typedef struct packed {
        logic signed [31:0] r00;
        logic signed [31:0] r01;
        logic signed [31:0] r02;
        logic signed [31:0] r10;
        logic signed [31:0] r11;
        logic signed [31:0] r12;
        logic signed [31:0] r20;
        logic signed [31:0] r21;
        logic signed [31:0] r22;
        logic               zero_axis;
    } t_out;

    // unit axis plus angle, from normalizer to CORDIC
    typedef struct packed {
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] uz;
        logic signed [31:0] angle;
        logic               zero;
    } t_norm;

    // unit axis plus cos and sin, from CORDIC to matrix stage
    typedef struct packed {
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] uz;
        logic signed [31:0] cx;
        logic signed [31:0] sy;
        logic               zero;
    } t_trig;

    function automatic t_wide atan_step(input int unsigned i);
        if (i < 11) begin
            return ATAN_LO[i[3:0]];
        end else if (i <= 30) begin
            return t_wide'(34'sd1 <<< (30 - i));
        end
        return '0;
    endfunction

    function automatic t_wide qmul(input t_wide a, input t_wide b);
        logic signed [2*ZW-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        return p[ZW+29:30];
    endfunction

    function automatic t_wide clamp_one(input t_wide v);
        if (v > FX_ONE) begin
            return FX_ONE;
        end else if (v < -FX_ONE) begin
            return -FX_ONE;
        end
        return v;
    endfunction

endpackage

@@ design/axis_angle_rotation_matrix.sv @@
// Throughput: one word per cycle; the whole pipeline advances together and holds
// while the output register is full and not taken.
// Latency is set by the 32-stage square root, the 31-stage dividers and the CORDIC.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
module axis_angle_rotation_matrix import aarm_pkg::*; #(
    parameter int CORDIC_STEPS  = 30,
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam logic signed [31:0] OUT_ONE = 32'sd1 <<< OUT_FRAC_BITS;

    logic  en;
    logic  norm_v;
    t_norm norm_d;
    logic  trig_v;
    t_trig trig_d;

    // advance everything unless the output word is stuck
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    aarm_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (norm_v),
        .o_data  (norm_d)
    );

    aarm_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (norm_v),
        .i_data  (norm_d),
        .o_valid (trig_v),
        .o_data  (trig_d)
    );

    aarm_mat #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (trig_v),
        .i_data  (trig_d),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    a_zero_axis_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_axis |->
            o_out_data.r00 == '0 && o_out_data.r01 == '0 && o_out_data.r02 == '0 &&
            o_out_data.r10 == '0 && o_out_data.r11 == '0 && o_out_data.r12 == '0 &&
            o_out_data.r20 == '0 && o_out_data.r21 == '0 && o_out_data.r22 == '0)
        else $error("zero axis word carries nonzero entries");

    a_diag_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_data.r00 <= OUT_ONE && o_out_data.r00 >= -OUT_ONE &&
            o_out_data.r11 <= OUT_ONE && o_out_data.r11 >= -OUT_ONE &&
            o_out_data.r22 <= OUT_ONE && o_out_data.r22 >= -OUT_ONE)
        else $error("diagonal entry outside [-1, 1]");

    a_stall_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output word is stalled");

endmodule

@@ design/aarm_norm.sv @@
// Axis normalizer: magnitude, scaling, sum of squares, pipelined square root and dividers
`timescale 1ns / 1ps
module aarm_norm import aarm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_in   i_data,
    output logic  o_valid,
    output t_norm o_data
);

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 31;

    typedef struct packed {
        logic [31:0]        m0;
        logic [31:0]        m1;
        logic [31:0]        m2;
        logic [2:0]         neg;
        logic               zero;
        logic signed [31:0] angle;
    } t_side;

    // stage 1: magnitudes
    t_side n1_side;
    t_side r1_side;
    logic  r1_v;

    always_comb begin
        n1_side.m0    = i_data.axis_x[31] ? 32'(-i_data.axis_x) : 32'(i_data.axis_x);
        n1_side.m1    = i_data.axis_y[31] ? 32'(-i_data.axis_y) : 32'(i_data.axis_y);
        n1_side.m2    = i_data.axis_z[31] ? 32'(-i_data.axis_z) : 32'(i_data.axis_z);
        n1_side.neg   = {i_data.axis_z[31], i_data.axis_y[31], i_data.axis_x[31]};
        n1_side.zero  = (i_data.axis_x == '0) && (i_data.axis_y == '0)
                        && (i_data.axis_z == '0);
        n1_side.angle = i_data.angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= n1_side;
        end
    end

    // stage 2: shift all three together until the largest reaches 2^30
    t_side       n2_side;
    logic [31:0] n2_m;
    t_side       r2_side;
    logic        r2_v;

    always_comb begin
        n2_side = r1_side;
        n2_m    = r1_side.m0;
        if (r1_side.m1 > n2_m) begin
            n2_m = r1_side.m1;
        end
        if (r1_side.m2 > n2_m) begin
            n2_m = r1_side.m2;
        end
        if (n2_m[31:15] == '0) begin
            n2_m = n2_m << 16;
            n2_side.m0 = n2_side.m0 << 16;
            n2_side.m1 = n2_side.m1 << 16;
            n2_side.m2 = n2_side.m2 << 16;
        end
        if (n2_m[31:23] == '0) begin
            n2_m = n2_m << 8;
            n2_side.m0 = n2_side.m0 << 8;
            n2_side.m1 = n2_side.m1 << 8;
            n2_side.m2 = n2_side.m2 << 8;
        end
        if (n2_m[31:27] == '0) begin
            n2_m = n2_m << 4;
            n2_side.m0 = n2_side.m0 << 4;
            n2_side.m1 = n2_side.m1 << 4;
            n2_side.m2 = n2_side.m2 << 4;
        end
        if (n2_m[31:29] == '0) begin
            n2_m = n2_m << 2;
            n2_side.m0 = n2_side.m0 << 2;
            n2_side.m1 = n2_side.m1 << 2;
            n2_side.m2 = n2_side.m2 << 2;
        end
        if (n2_m[31:30] == '0) begin
            n2_side.m0 = n2_side.m0 << 1;
            n2_side.m1 = n2_side.m1 << 1;
            n2_side.m2 = n2_side.m2 << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side <= n2_side;
        end
    end

    // stage 3: squares
    t_side       r3_side;
    logic [63:0] r3_sq [3];
    logic        r3_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_side  <= r2_side;
            r3_sq[0] <= 64'(r2_side.m0) * 64'(r2_side.m0);
            r3_sq[1] <= 64'(r2_side.m1) * 64'(r2_side.m1);
            r3_sq[2] <= 64'(r2_side.m2) * 64'(r2_side.m2);
        end
    end

    // stage 4 feeds entry 0 of the root pipeline with the sum
    logic [63:0] r_sq_s    [0:SQ_STEPS];
    logic [63:0] r_sq_r    [0:SQ_STEPS];
    t_side       r_sq_side [0:SQ_STEPS];
    logic        r_sq_v    [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (i_en) begin
            r_sq_v[0] <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_s[0]    <= r3_sq[0] + r3_sq[1] + r3_sq[2];
            r_sq_r[0]    <= '0;
            r_sq_side[0] <= r3_side;
        end
    end

    // integer square root, one result bit per stage
    for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (j - 1));
        logic [63:0] trial;

        assign trial = r_sq_r[j-1] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j] <= 1'b0;
            end else if (i_en) begin
                r_sq_v[j] <= r_sq_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_side[j] <= r_sq_side[j-1];
                if (r_sq_s[j-1] >= trial) begin
                    r_sq_s[j] <= r_sq_s[j-1] - trial;
                    r_sq_r[j] <= (r_sq_r[j-1] >> 1) + BIT;
                end else begin
                    r_sq_s[j] <= r_sq_s[j-1];
                    r_sq_r[j] <= r_sq_r[j-1] >> 1;
                end
            end
        end
    end

    // entry 0 of the divider pipeline holds the rounded numerators
    logic [63:0] r_dv_rem  [0:DIV_STEPS][3];
    logic [30:0] r_dv_q    [0:DIV_STEPS][3];
    logic [31:0] r_dv_nrm  [0:DIV_STEPS];
    t_side       r_dv_side [0:DIV_STEPS];
    logic        r_dv_v    [0:DIV_STEPS];
    logic [31:0] nrm;

    assign nrm = r_sq_r[SQ_STEPS][31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_v[0] <= r_sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_rem[0][0] <= (64'(r_sq_side[SQ_STEPS].m0) << 30) + 64'(nrm >> 1);
            r_dv_rem[0][1] <= (64'(r_sq_side[SQ_STEPS].m1) << 30) + 64'(nrm >> 1);
            r_dv_rem[0][2] <= (64'(r_sq_side[SQ_STEPS].m2) << 30) + 64'(nrm >> 1);
            r_dv_q[0][0]   <= '0;
            r_dv_q[0][1]   <= '0;
            r_dv_q[0][2]   <= '0;
            r_dv_nrm[0]    <= nrm;
            r_dv_side[0]   <= r_sq_side[SQ_STEPS];
        end
    end

    // restoring division, quotient bit 30 down to bit 0
    for (genvar t = 1; t <= DIV_STEPS; t++) begin : g_div
        localparam int          B    = DIV_STEPS - t;
        localparam logic [30:0] QBIT = 31'd1 << B;
        logic [63:0] dvs;

        assign dvs = 64'(r_dv_nrm[t-1]) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[t] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[t] <= r_dv_v[t-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_nrm[t]  <= r_dv_nrm[t-1];
                r_dv_side[t] <= r_dv_side[t-1];
                for (int k = 0; k < 3; k++) begin
                    if (r_dv_rem[t-1][k] >= dvs) begin
                        r_dv_rem[t][k] <= r_dv_rem[t-1][k] - dvs;
                        r_dv_q[t][k]   <= r_dv_q[t-1][k] | QBIT;
                    end else begin
                        r_dv_rem[t][k] <= r_dv_rem[t-1][k];
                        r_dv_q[t][k]   <= r_dv_q[t-1][k];
                    end
                end
            end
        end
    end

    // apply signs
    t_side       last;
    logic [31:0] qx;
    logic [31:0] qy;
    logic [31:0] qz;
    t_norm       r_out;
    logic        r_out_v;

    assign last = r_dv_side[DIV_STEPS];
    assign qx   = {1'b0, r_dv_q[DIV_STEPS][0]};
    assign qy   = {1'b0, r_dv_q[DIV_STEPS][1]};
    assign qz   = {1'b0, r_dv_q[DIV_STEPS][2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_dv_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.ux    <= last.neg[0] ? -$signed(qx) : $signed(qx);
            r_out.uy    <= last.neg[1] ? -$signed(qy) : $signed(qy);
            r_out.uz    <= last.neg[2] ? -$signed(qz) : $signed(qz);
            r_out.angle <= last.angle;
            r_out.zero  <= last.zero;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

@@ design/aarm_cordic.sv @@
// Angle reduction and pipelined rotation-mode CORDIC for cosine and sine
`timescale 1ns / 1ps
module aarm_cordic import aarm_pkg::*; #(
    parameter int CORDIC_STEPS = 30
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_norm i_data,
    output logic  o_valid,
    output t_trig o_data
);

    // stage A: scale to 30 fraction bits and wrap into [-pi, pi]
    t_wide n_a_z;
    t_wide z4;
    t_wide r_a_z;
    t_norm r_a_side;
    logic  r_a_v;

    assign z4 = {i_data.angle, 2'b00};

    always_comb begin
        n_a_z = z4;
        if (z4 > FX_PI) begin
            n_a_z = z4 - FX_TWO_PI;
        end else if (z4 < -FX_PI) begin
            n_a_z = z4 + FX_TWO_PI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_z    <= n_a_z;
            r_a_side <= i_data;
        end
    end

    // entry 0 is the fold stage; entries 1..CORDIC_STEPS are rotations
    t_wide r_x    [0:CORDIC_STEPS];
    t_wide r_y    [0:CORDIC_STEPS];
    t_wide r_z    [0:CORDIC_STEPS];
    logic  r_flip [0:CORDIC_STEPS];
    t_norm r_side [0:CORDIC_STEPS];
    logic  r_v    [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r_a_v;
        end
    end

    // fold into [-pi/2, pi/2], negate the results later
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= FX_GAIN;
            r_y[0]    <= '0;
            r_side[0] <= r_a_side;
            if (r_a_z > FX_HALF_PI) begin
                r_z[0]    <= r_a_z - FX_PI;
                r_flip[0] <= 1'b1;
            end else if (r_a_z < -FX_HALF_PI) begin
                r_z[0]    <= r_a_z + FX_PI;
                r_flip[0] <= 1'b1;
            end else begin
                r_z[0]    <= r_a_z;
                r_flip[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 1; i <= CORDIC_STEPS; i++) begin : g_rot
        localparam t_wide ANG = atan_step(i - 1);
        t_wide dx;
        t_wide dy;

        assign dx = r_y[i-1] >>> (i - 1);
        assign dy = r_x[i-1] >>> (i - 1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_en) begin
                r_v[i] <= r_v[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[i] <= r_flip[i-1];
                r_side[i] <= r_side[i-1];
                if (!r_z[i-1][ZW-1]) begin
                    r_x[i] <= r_x[i-1] - dx;
                    r_y[i] <= r_y[i-1] + dy;
                    r_z[i] <= r_z[i-1] - ANG;
                end else begin
                    r_x[i] <= r_x[i-1] + dx;
                    r_y[i] <= r_y[i-1] - dy;
                    r_z[i] <= r_z[i-1] + ANG;
                end
            end
        end
    end

    // undo the fold and clamp
    t_wide fx;
    t_wide fy;
    t_wide cx;
    t_wide sy;
    t_trig r_out;
    logic  r_out_v;

    assign fx = r_flip[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
    assign fy = r_flip[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
    assign cx = clamp_one(fx);
    assign sy = clamp_one(fy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.ux   <= r_side[CORDIC_STEPS].ux;
            r_out.uy   <= r_side[CORDIC_STEPS].uy;
            r_out.uz   <= r_side[CORDIC_STEPS].uz;
            r_out.zero <= r_side[CORDIC_STEPS].zero;
            r_out.cx   <= cx[31:0];
            r_out.sy   <= sy[31:0];
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

@@ design/aarm_mat.sv @@
// Rodrigues matrix products, sums and output rounding
`timescale 1ns / 1ps
module aarm_mat import aarm_pkg::*; #(
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_trig i_data,
    output logic  o_valid,
    output t_out  o_data
);

    localparam int    RND  = 30 - OUT_FRAC_BITS;
    localparam t_wide HALF = t_wide'((64'd1 << RND) >> 1);

    t_wide ux;
    t_wide uy;
    t_wide uz;
    t_wide sn;

    assign ux = t_wide'(i_data.ux);
    assign uy = t_wide'(i_data.uy);
    assign uz = t_wide'(i_data.uz);
    assign sn = t_wide'(i_data.sy);

    // stage 1: axis outer products and sine terms
    // p: xx yy zz xy xz yz, s: x*s y*s z*s
    t_wide r1_p [6];
    t_wide r1_s [3];
    t_wide r1_omc;
    t_wide r1_cx;
    logic  r1_zero;
    logic  r1_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p[0] <= qmul(ux, ux);
            r1_p[1] <= qmul(uy, uy);
            r1_p[2] <= qmul(uz, uz);
            r1_p[3] <= qmul(ux, uy);
            r1_p[4] <= qmul(ux, uz);
            r1_p[5] <= qmul(uy, uz);
            r1_s[0] <= qmul(ux, sn);
            r1_s[1] <= qmul(uy, sn);
            r1_s[2] <= qmul(uz, sn);
            r1_omc  <= FX_ONE - t_wide'(i_data.cx);
            r1_cx   <= t_wide'(i_data.cx);
            r1_zero <= i_data.zero;
        end
    end

    // stage 2: scale by one minus cosine
    t_wide r2_t [6];
    t_wide r2_s [3];
    t_wide r2_cx;
    logic  r2_zero;
    logic  r2_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 6; k++) begin
                r2_t[k] <= qmul(r1_p[k], r1_omc);
            end
            r2_s    <= r1_s;
            r2_cx   <= r1_cx;
            r2_zero <= r1_zero;
        end
    end

    // stage 3: entries
    t_wide r3_e [9];
    logic  r3_zero;
    logic  r3_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_e[0] <= r2_cx + r2_t[0];
            r3_e[1] <= r2_t[3] - r2_s[2];
            r3_e[2] <= r2_t[4] + r2_s[1];
            r3_e[3] <= r2_t[3] + r2_s[2];
            r3_e[4] <= r2_cx + r2_t[1];
            r3_e[5] <= r2_t[5] - r2_s[0];
            r3_e[6] <= r2_t[4] - r2_s[1];
            r3_e[7] <= r2_t[5] + r2_s[0];
            r3_e[8] <= r2_cx + r2_t[2];
            r3_zero <= r2_zero;
        end
    end

    // stage 4: clamp, round to the output format, zero a zero-axis word, output register
    t_wide n_e [9];
    t_out  r_out;
    logic  r_out_v;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_e[k] = (clamp_one(r3_e[k]) + HALF) >>> RND;
            if (r3_zero) begin
                n_e[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.r00       <= n_e[0][31:0];
            r_out.r01       <= n_e[1][31:0];
            r_out.r02       <= n_e[2][31:0];
            r_out.r10       <= n_e[3][31:0];
            r_out.r11       <= n_e[4][31:0];
            r_out.r12       <= n_e[5][31:0];
            r_out.r20       <= n_e[6][31:0];
            r_out.r21       <= n_e[7][31:0];
            r_out.r22       <= n_e[8][31:0];
            r_out.zero_axis <= r3_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r_out_v <= r3_v;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

@@ test/axis_angle_rotation_matrix_tb.sv @@
// Testbench for the axis-angle to rotation matrix pipeline: directed table plus random words
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_tb;
    import aarm_pkg::*;

    localparam int STEPS     = 30;
    localparam int FRAC      = 30;
    localparam int LATENCY   = STEPS + 76;
    localparam int N_RANDOM  = 1030;
    localparam int CYCLE_MAX = 400000;
    localparam longint ONE     = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint HPI_Q30 = 64'sd1686629713;
    localparam longint TPI_Q30 = 64'sd6746518852;
    localparam longint GAIN    = 64'sd652032874;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    axis_angle_rotation_matrix #(.CORDIC_STEPS(STEPS), .OUT_FRAC_BITS(FRAC)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_out   matrix_q[$];
    int     n_errors = 0;
    int     n_matrices = 0;
    int     n_zero_axis = 0;
    longint cycles = 0;
    bit     no_idle = 1'b0;
    bit     long_hold = 1'b0;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint mulq(longint a, longint b);
        return fshift(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic longint sat_one(longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    function automatic longint arctan_q30(int i);
        longint lo [0:10];
        lo = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
               16775851, 8388437, 4194283, 2097149, 1048576};
        if (i < 11) return lo[i];
        if (i <= 30) return 64'sd1 <<< (30 - i);
        return 0;
    endfunction

    function automatic logic [31:0] to_out(longint v);
        int s;
        v = sat_one(v);
        if (FRAC < 30) begin
            s = 30 - FRAC;
            v = fshift(v + (64'sd1 <<< (s - 1)), s);
        end
        return v[31:0];
    endfunction

    function automatic longint usqrt(longint unsigned s);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_out rotation_matrix(t_in w);
        t_out r;
        longint unsigned mag [3];
        longint unsigned mx, sum, nrm, q;
        bit neg [3];
        longint u [3];
        longint raw [3];
        longint z, cx, sy, nx, ny, dx, dy, omc, xy, xz, yz;
        longint e [9];
        bit flip;
        r = '0;
        flip = 0;
        raw[0] = w.axis_x;
        raw[1] = w.axis_y;
        raw[2] = w.axis_z;
        for (int k = 0; k < 3; k++) begin
            neg[k] = raw[k] < 0;
            mag[k] = neg[k] ? -raw[k] : raw[k];
        end
        mx = mag[0];
        if (mag[1] > mx) mx = mag[1];
        if (mag[2] > mx) mx = mag[2];
        if (mx == 0) begin
            r.zero_axis = 1'b1;
            return r;
        end
        while (mx < (64'd1 << 30)) begin
            mx <<= 1;
            for (int k = 0; k < 3; k++) mag[k] <<= 1;
        end
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        nrm = usqrt(sum);
        for (int k = 0; k < 3; k++) begin
            q = ((mag[k] << 30) + (nrm >> 1)) / nrm;
            if (q > ONE) q = ONE;
            u[k] = neg[k] ? -longint'(q) : longint'(q);
        end
        z = longint'(w.angle) * 4;
        while (z > PI_Q30) z -= TPI_Q30;
        while (z < -PI_Q30) z += TPI_Q30;
        if (z > HPI_Q30) begin
            z -= PI_Q30;
            flip = 1;
        end else if (z < -HPI_Q30) begin
            z += PI_Q30;
            flip = 1;
        end
        cx = GAIN;
        sy = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = fshift(sy, i);
            dy = fshift(cx, i);
            if (z >= 0) begin
                nx = cx - dx; ny = sy + dy; z -= arctan_q30(i);
            end else begin
                nx = cx + dx; ny = sy - dy; z += arctan_q30(i);
            end
            cx = nx;
            sy = ny;
        end
        if (flip) begin
            cx = -cx;
            sy = -sy;
        end
        cx = sat_one(cx);
        sy = sat_one(sy);
        omc = ONE - cx;
        xy = mulq(mulq(u[0], u[1]), omc);
        xz = mulq(mulq(u[0], u[2]), omc);
        yz = mulq(mulq(u[1], u[2]), omc);
        e[0] = cx + mulq(mulq(u[0], u[0]), omc);
        e[1] = xy - mulq(u[2], sy);
        e[2] = xz + mulq(u[1], sy);
        e[3] = xy + mulq(u[2], sy);
        e[4] = cx + mulq(mulq(u[1], u[1]), omc);
        e[5] = yz - mulq(u[0], sy);
        e[6] = xz - mulq(u[1], sy);
        e[7] = yz + mulq(u[0], sy);
        e[8] = cx + mulq(mulq(u[2], u[2]), omc);
        r.r00 = to_out(e[0]); r.r01 = to_out(e[1]); r.r02 = to_out(e[2]);
        r.r10 = to_out(e[3]); r.r11 = to_out(e[4]); r.r12 = to_out(e[5]);
        r.r20 = to_out(e[6]); r.r21 = to_out(e[7]); r.r22 = to_out(e[8]);
        return r;
    endfunction

    // directed rows: axis, angle, and a typed-in matrix where it is obvious
    typedef struct {
        t_in  word;
        bit   typed;
        t_out matrix;
    } t_row;

    t_row rows[$];

    function automatic t_in mk(int x, int y, int z, int a);
        t_in w;
        w.axis_x = x; w.axis_y = y; w.axis_z = z; w.angle = a;
        return w;
    endfunction

    task automatic add_row(t_in w, bit typed, t_out m);
        t_row r;
        r.word = w; r.typed = typed; r.matrix = m;
        rows.push_back(r);
    endtask

    task automatic build_table();
        t_out zero_m, ident;
        zero_m = '0;
        zero_m.zero_axis = 1'b1;
        ident = '0;
        ident.r00 = 32'sd1 <<< FRAC;
        ident.r11 = 32'sd1 <<< FRAC;
        ident.r22 = 32'sd1 <<< FRAC;
        add_row(mk(0, 0, 0, 0), 1, zero_m);
        add_row(mk(0, 0, 0, 32'h7fffffff), 1, zero_m);
        add_row(mk(0, 0, 0, 32'h80000000), 1, zero_m);
        add_row(mk(32'h80000000, 0, 0, 0), 0, ident);
        add_row(mk(32'h7fffffff, 0, 0, 32'h7fffffff), 0, ident);
        add_row(mk(0, 32'h80000000, 0, 32'h80000000), 0, ident);
        add_row(mk(0, 0, 32'h7fffffff, 32'h1921fb54), 0, ident);
        add_row(mk(1, 0, 0, 32'h3243f6a9), 0, ident);
        add_row(mk(-1, -1, -1, 32'h0c90fdaa), 0, ident);
        add_row(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'hcdbc0957), 0, ident);
        add_row(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1), 0, ident);
        add_row(mk(32'h00010000, 32'h00020000, 32'h00030000, 32'h6487ed51), 0, ident);
        add_row(mk(32'h00010000, 0, 32'hffff0000, 32'h9b7812af), 0, ident);
        add_row(mk(3, 32'h7fffffff, 32'h80000000, 32'h1921fb55), 0, ident);
        add_row(mk(0, 1, 0, 32'hffffffff), 0, ident);
        add_row(mk(32'h55555555, 32'haaaaaaaa, 32'h12345678, 32'h40000000), 0, ident);
    endtask

    task automatic send(t_in w);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic sender_gap();
        int n;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            n = $urandom_range(1, 6);
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic t_in random_word();
        t_in w;
        int sel;
        w.axis_x = $urandom;
        w.axis_y = $urandom;
        w.axis_z = $urandom;
        w.angle  = $urandom;
        sel = $urandom_range(0, 9);
        // bias some words toward small axes, single-axis and zero axes, and small angles
        if (sel == 0) begin
            w.axis_x = 0; w.axis_y = 0; w.axis_z = 0;
        end else if (sel == 1) begin
            w.axis_x = $signed($urandom_range(0, 8)) - 4;
            w.axis_y = $signed($urandom_range(0, 8)) - 4;
            w.axis_z = $signed($urandom_range(0, 8)) - 4;
        end else if (sel == 2) begin
            w.axis_y = 0; w.axis_z = 0;
        end else if (sel == 3) begin
            w.angle = $signed($urandom_range(0, 200)) - 100;
        end
        return w;
    endfunction

    // stimulus
    initial begin
        t_in w;
        build_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) begin
            w = rows[i].word;
            matrix_q.push_back(rows[i].typed ? rows[i].matrix : rotation_matrix(w));
            send(w);
            sender_gap();
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 200) long_hold = 1'b1;
            if (i == 500) begin
                // pause until the pipeline drains
                i_in_valid <= 1'b0;
                while (matrix_q.size() != 0) @(posedge i_clk);
            end
            if (i == N_RANDOM - 150) no_idle = 1'b1;
            w = random_word();
            matrix_q.push_back(rotation_matrix(w));
            send(w);
            sender_gap();
        end
        i_in_valid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d matrices (%0d zero-axis) with backpressure and gaps.",
                 n_matrices, n_zero_axis);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // receiver stalls, including one long hold-off
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                i_out_ready <= 1'b0;
                repeat (3 * LATENCY) @(posedge i_clk);
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 6);
                repeat (n) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // compare accepted words against the predicted matrices
    always @(posedge i_clk) begin
        t_out e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (matrix_q.size() == 0) begin
                $error("unexpected output word %h", o_out_data);
                n_errors++;
            end else begin
                e = matrix_q.pop_front();
                n_matrices++;
                if (e.zero_axis) n_zero_axis++;
                if (o_out_data.r00 !== e.r00) begin
                    $error("r00 exp %h got %h", e.r00, o_out_data.r00); n_errors++;
                end
                if (o_out_data.r01 !== e.r01) begin
                    $error("r01 exp %h got %h", e.r01, o_out_data.r01); n_errors++;
                end
                if (o_out_data.r02 !== e.r02) begin
                    $error("r02 exp %h got %h", e.r02, o_out_data.r02); n_errors++;
                end
                if (o_out_data.r10 !== e.r10) begin
                    $error("r10 exp %h got %h", e.r10, o_out_data.r10); n_errors++;
                end
                if (o_out_data.r11 !== e.r11) begin
                    $error("r11 exp %h got %h", e.r11, o_out_data.r11); n_errors++;
                end
                if (o_out_data.r12 !== e.r12) begin
                    $error("r12 exp %h got %h", e.r12, o_out_data.r12); n_errors++;
                end
                if (o_out_data.r20 !== e.r20) begin
                    $error("r20 exp %h got %h", e.r20, o_out_data.r20); n_errors++;
                end
                if (o_out_data.r21 !== e.r21) begin
                    $error("r21 exp %h got %h", e.r21, o_out_data.r21); n_errors++;
                end
                if (o_out_data.r22 !== e.r22) begin
                    $error("r22 exp %h got %h", e.r22, o_out_data.r22); n_errors++;
                end
                if (o_out_data.zero_axis !== e.zero_axis) begin
                    $error("zero_axis exp %b got %b", e.zero_axis, o_out_data.zero_axis);
                    n_errors++;
                end
            end
        end
    end

endmodule
